// ----- design/mpbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the matrix power block.
package mpbs_pkg;

	// Input item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_POWER = 1'b1;

	// Configuration register index, taken from paddr[2]
	localparam logic REG_DIMENSION = 1'b0;

	// Reset value of the dimension register
	localparam logic [3:0] DIM_RESET = 4'd8;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_MUL_RS,
		OP_MUL_SS,
		OP_COPY_R,
		OP_COPY_S,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] row;
		logic [2:0] col;
		logic [2:0] mid;
		logic [1:0] phase;
		logic       first;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_DRAIN,
		ST_CHECK,
		ST_SHIFT,
		ST_MUL,
		ST_COPY,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

// ----- design/mpbs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface mpbs_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [2:0]         row_index;
	logic [2:0]         col_index;
	logic signed [31:0] element_value;
	logic [30:0]        exponent;

	modport source (output valid, kind, row_index, col_index, element_value, exponent,
		input ready);
	modport sink (input valid, kind, row_index, col_index, element_value, exponent,
		output ready);
endinterface

interface mpbs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic               last;

	modport source (output valid, result_value, out_row, out_col, last, input ready);
	modport sink (input valid, result_value, out_row, out_col, last, output ready);
endinterface

// ----- design/matrix_power_by_squaring.sv -----
`timescale 1ns / 1ps
// Raises a loaded square integer matrix to a power by square-and-multiply; top level.
//
// A load transaction (kind 0) writes one base element and the block is ready again at
// once. A power transaction (kind 1) with exponent e on an n x n matrix runs one shared
// multiply-accumulate unit over four single-port-write stores: a set-up sweep copies
// the base into the square store and sets the result store to the identity, then each
// matrix product (one per set bit of e, and one squaring for each bit position above
// bit 0 up to the highest set bit of e) takes a multiply-accumulate sweep, a drain and
// a sweep that copies the product back. Each inner term is one partial product for
// DATA_WIDTH up to 32 and is built from three 32-bit partial products above. Results
// leave row-major through an output register, so the last result may wait there while
// new load transactions are taken. Products and sums wrap modulo 2^DATA_WIDTH;
// result_value carries the low 32 bits. dimension (APB offset 0) holds pwdata[3:0] and
// reads back as written; 0 acts as 1 and values above MAX_DIM act as MAX_DIM. Each base
// element used by a power transaction must be loaded first.
module matrix_power_by_squaring #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mpbs_in_if.sink     req,
	mpbs_out_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NUM_PHASES = (DATA_WIDTH > 32) ? 3 : 1;

	logic [3:0] dim_q;
	logic [3:0] dim_use;
	logic       in_ready;

	mpbs_pkg::cmd_t    cmd;
	mpbs_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= mpbs_pkg::DIM_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == mpbs_pkg::REG_DIMENSION)) begin
			dim_q <= pwdata[3:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mpbs_pkg::REG_DIMENSION) ? {28'd0, dim_q} : 32'd0;

	always_comb begin
		if (dim_q == 4'd0) begin
			dim_use = 4'd1;
		end else if (dim_q > 4'(MAX_DIM)) begin
			dim_use = 4'(MAX_DIM);
		end else begin
			dim_use = dim_q;
		end
	end

	assign req.ready = in_ready;

	mpbs_ctrl #(.NUM_PHASES(NUM_PHASES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.dim         (dim_use),
		.in_valid    (req.valid),
		.in_kind     (req.kind),
		.in_exponent (req.exponent),
		.in_ready    (in_ready),
		.status      (status),
		.cmd         (cmd)
	);

	mpbs_dp #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_row   (req.row_index),
		.in_col   (req.col_index),
		.in_value (req.element_value),
		.res      (res)
	);

endmodule

// ----- design/mpbs_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module mpbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]                             rd_data_a,
	output logic [WIDTH-1:0]                             rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ----- design/mpbs_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: walks load, init, square-and-multiply, copy and emit sweeps.
module mpbs_ctrl #(
	parameter int NUM_PHASES = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          dim,
	input  logic                in_valid,
	input  logic                in_kind,
	input  logic [30:0]         in_exponent,
	output logic                in_ready,
	input  mpbs_pkg::status_t   status,
	output mpbs_pkg::cmd_t      cmd
);

	mpbs_pkg::state_t state_q, state_d;
	mpbs_pkg::state_t ret_q, ret_d;
	logic        sq_q, sq_d;
	logic [30:0] e_q, e_d;
	logic [2:0]  row_q, row_d, col_q, col_d, mid_q, mid_d;
	logic [1:0]  ph_q, ph_d;

	logic [2:0] nm1;
	logic       row_end, col_end, mid_end, ph_end, sweep_end;

	assign nm1       = 3'(dim - 4'd1);
	assign row_end   = (row_q == nm1);
	assign col_end   = (col_q == nm1);
	assign mid_end   = (mid_q == nm1);
	assign ph_end    = (ph_q == 2'(NUM_PHASES - 1));
	assign sweep_end = row_end && col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpbs_pkg::ST_IDLE;
			ret_q   <= mpbs_pkg::ST_IDLE;
			sq_q    <= 1'b0;
			e_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			mid_q   <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			sq_q    <= sq_d;
			e_q     <= e_d;
			row_q   <= row_d;
			col_q   <= col_d;
			mid_q   <= mid_d;
			ph_q    <= ph_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		sq_d      = sq_q;
		e_d       = e_q;
		row_d     = row_q;
		col_d     = col_q;
		mid_d     = mid_q;
		ph_d      = ph_q;
		in_ready  = 1'b0;
		cmd.op    = mpbs_pkg::OP_NONE;
		cmd.row   = row_q;
		cmd.col   = col_q;
		cmd.mid   = mid_q;
		cmd.phase = ph_q;
		cmd.first = (mid_q == 3'd0) && (ph_q == 2'd0);
		cmd.last  = mid_end && ph_end;

		case (state_q)
			mpbs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == mpbs_pkg::KIND_LOAD) begin
						cmd.op = mpbs_pkg::OP_LOAD;
					end else begin
						e_d     = in_exponent;
						row_d   = '0;
						col_d   = '0;
						mid_d   = '0;
						ph_d    = '0;
						state_d = mpbs_pkg::ST_INIT;
					end
				end
			end
			mpbs_pkg::ST_INIT: begin
				cmd.op = mpbs_pkg::OP_INIT;
				if (sweep_end) begin
					row_d   = '0;
					col_d   = '0;
					ret_d   = mpbs_pkg::ST_CHECK;
					state_d = mpbs_pkg::ST_DRAIN;
				end else if (col_end) begin
					col_d = '0;
					row_d = row_q + 3'd1;
				end else begin
					col_d = col_q + 3'd1;
				end
			end
			mpbs_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_d = ret_q;
				end
			end
			mpbs_pkg::ST_CHECK: begin
				if (e_q[0]) begin
					sq_d    = 1'b0;
					state_d = mpbs_pkg::ST_MUL;
				end else begin
					state_d = mpbs_pkg::ST_SHIFT;
				end
			end
			mpbs_pkg::ST_SHIFT: begin
				e_d = e_q >> 1;
				if (e_q[30:1] == 30'd0) begin
					state_d = mpbs_pkg::ST_EMIT_RD;
				end else begin
					sq_d    = 1'b1;
					state_d = mpbs_pkg::ST_MUL;
				end
			end
			mpbs_pkg::ST_MUL: begin
				cmd.op = sq_q ? mpbs_pkg::OP_MUL_SS : mpbs_pkg::OP_MUL_RS;
				// phase, then inner index, then column, then row
				if (!ph_end) begin
					ph_d = ph_q + 2'd1;
				end else begin
					ph_d = '0;
					if (!mid_end) begin
						mid_d = mid_q + 3'd1;
					end else begin
						mid_d = '0;
						if (sweep_end) begin
							row_d   = '0;
							col_d   = '0;
							ret_d   = mpbs_pkg::ST_COPY;
							state_d = mpbs_pkg::ST_DRAIN;
						end else if (col_end) begin
							col_d = '0;
							row_d = row_q + 3'd1;
						end else begin
							col_d = col_q + 3'd1;
						end
					end
				end
			end
			mpbs_pkg::ST_COPY: begin
				cmd.op = sq_q ? mpbs_pkg::OP_COPY_S : mpbs_pkg::OP_COPY_R;
				if (sweep_end) begin
					row_d   = '0;
					col_d   = '0;
					ret_d   = sq_q ? mpbs_pkg::ST_CHECK : mpbs_pkg::ST_SHIFT;
					state_d = mpbs_pkg::ST_DRAIN;
				end else if (col_end) begin
					col_d = '0;
					row_d = row_q + 3'd1;
				end else begin
					col_d = col_q + 3'd1;
				end
			end
			mpbs_pkg::ST_EMIT_RD: begin
				state_d = mpbs_pkg::ST_EMIT_LD;
			end
			mpbs_pkg::ST_EMIT_LD: begin
				cmd.last = sweep_end;
				if (status.out_free) begin
					cmd.op = mpbs_pkg::OP_EMIT;
					if (sweep_end) begin
						row_d   = '0;
						col_d   = '0;
						state_d = mpbs_pkg::ST_IDLE;
					end else begin
						if (col_end) begin
							col_d = '0;
							row_d = row_q + 3'd1;
						end else begin
							col_d = col_q + 3'd1;
						end
						state_d = mpbs_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = mpbs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/mpbs_dp.sv -----
`timescale 1ns / 1ps
// Datapath: matrix stores, multiply-accumulate pipeline and result register.
module mpbs_dp #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mpbs_pkg::cmd_t     cmd,
	output mpbs_pkg::status_t  status,
	input  logic [2:0]         in_row,
	input  logic [2:0]         in_col,
	input  logic signed [31:0] in_value,
	mpbs_out_if.source         res
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int DW    = DATA_WIDTH;

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	function automatic logic [AW-1:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		logic [6:0] lin;
		lin = 7'(r) * 7'(MAX_DIM) + 7'(c);
		return lin[AW-1:0];
	endfunction

	// stage 0 addresses
	logic [AW-1:0] a_rc, a_rm, a_mc, a_load, r_rd_addr;
	logic          load_we;

	assign a_rc      = cell_addr(cmd.row, cmd.col);
	assign a_rm      = cell_addr(cmd.row, cmd.mid);
	assign a_mc      = cell_addr(cmd.mid, cmd.col);
	assign a_load    = cell_addr(in_row, in_col);
	assign r_rd_addr = (cmd.op == mpbs_pkg::OP_MUL_RS) ? a_rm : a_rc;
	assign load_we   = (cmd.op == mpbs_pkg::OP_LOAD)
		&& ({1'b0, in_row} < 4'(MAX_DIM)) && ({1'b0, in_col} < 4'(MAX_DIM));

	// stage 1 tags
	mpbs_pkg::op_t op_s1;
	logic [AW-1:0] rc_s1;
	logic          diag_s1, first_s1, last_s1;

	// stage 2 tags and product
	logic          mac_s2, first_s2, last_s2;
	logic [AW-1:0] dst_s2;
	logic [DW-1:0] prod_s2;
	logic [DW-1:0] acc_q, sum;

	// store read and write signals
	logic [DW-1:0] b_rd, s_rd_a, s_rd_b, r_rd, p_rd;
	logic          s_we, r_we, p_we;
	logic [DW-1:0] s_wr, r_wr;
	logic [DW-1:0] opa_s1, term_s1;
	logic          mac_s1;

	// out register
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [2:0]         out_row_q, out_col_q;
	logic               out_last_q;

	assign mac_s1 = (op_s1 == mpbs_pkg::OP_MUL_RS) || (op_s1 == mpbs_pkg::OP_MUL_SS);
	assign opa_s1 = (op_s1 == mpbs_pkg::OP_MUL_SS) ? s_rd_a : r_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= mpbs_pkg::OP_NONE;
			mac_s2 <= 1'b0;
		end else begin
			op_s1  <= cmd.op;
			mac_s2 <= mac_s1;
		end
	end

	always_ff @(posedge clk) begin
		rc_s1    <= a_rc;
		diag_s1  <= (cmd.row == cmd.col);
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		prod_s2  <= term_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		dst_s2   <= rc_s1;
		if (mac_s2) begin
			acc_q <= sum;
		end
	end

	generate
		if (DW > 32) begin : g_split
			localparam int HW = DW - 32;
			logic [1:0]  phase_s1;
			logic [31:0] mx, my;
			logic [63:0] pp;

			always_ff @(posedge clk) begin
				phase_s1 <= cmd.phase;
			end

			// three 32-bit partial products; the high-by-high term wraps away
			always_comb begin
				case (phase_s1)
					PH_LH: begin
						mx = opa_s1[31:0];
						my = 32'(s_rd_b[DW-1:32]);
					end
					PH_HL: begin
						mx = 32'(opa_s1[DW-1:32]);
						my = s_rd_b[31:0];
					end
					default: begin
						mx = opa_s1[31:0];
						my = s_rd_b[31:0];
					end
				endcase
			end

			assign pp      = 64'(mx) * 64'(my);
			assign term_s1 = (phase_s1 == PH_LL) ? pp[DW-1:0] : {pp[HW-1:0], 32'd0};
		end else begin : g_single
			logic [2*DW-1:0] pfull;
			assign pfull   = (2*DW)'(opa_s1) * (2*DW)'(s_rd_b);
			assign term_s1 = pfull[DW-1:0];
		end
	endgenerate

	assign sum  = (first_s2 ? '0 : acc_q) + prod_s2;
	assign p_we = mac_s2 && last_s2;

	assign s_we = (op_s1 == mpbs_pkg::OP_INIT) || (op_s1 == mpbs_pkg::OP_COPY_S);
	assign s_wr = (op_s1 == mpbs_pkg::OP_INIT) ? b_rd : p_rd;
	assign r_we = (op_s1 == mpbs_pkg::OP_INIT) || (op_s1 == mpbs_pkg::OP_COPY_R);
	assign r_wr = (op_s1 == mpbs_pkg::OP_INIT) ? DW'(diag_s1) : p_rd;

	mpbs_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_base (
		.clk(clk), .we(load_we), .wr_addr(a_load), .wr_data(DW'(in_value)),
		.rd_addr_a(a_rc), .rd_addr_b(a_rc), .rd_data_a(b_rd), .rd_data_b()
	);

	mpbs_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_square (
		.clk(clk), .we(s_we), .wr_addr(rc_s1), .wr_data(s_wr),
		.rd_addr_a(a_rm), .rd_addr_b(a_mc), .rd_data_a(s_rd_a), .rd_data_b(s_rd_b)
	);

	mpbs_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_result (
		.clk(clk), .we(r_we), .wr_addr(rc_s1), .wr_data(r_wr),
		.rd_addr_a(r_rd_addr), .rd_addr_b(r_rd_addr), .rd_data_a(r_rd), .rd_data_b()
	);

	mpbs_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_scratch (
		.clk(clk), .we(p_we), .wr_addr(dst_s2), .wr_data(sum),
		.rd_addr_a(a_rc), .rd_addr_b(a_rc), .rd_data_a(p_rd), .rd_data_b()
	);

	// result register; loaded only when free or being taken this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == mpbs_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mpbs_pkg::OP_EMIT) begin
			out_value_q <= 32'(r_rd);
			out_row_q   <= cmd.row;
			out_col_q   <= cmd.col;
			out_last_q  <= cmd.last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_value = out_value_q;
	assign res.out_row      = out_row_q;
	assign res.out_col      = out_col_q;
	assign res.last         = out_last_q;

	assign status.busy     = (op_s1 != mpbs_pkg::OP_NONE) || mac_s2;
	assign status.out_free = !out_valid_q || res.ready;

endmodule
